// ===== sv/gedge_pkg.sv =====
// Shared types and constants of the wraparound gradient edge block.
// No dependencies; imported by every module of the block.
`default_nettype none

package gedge_pkg;

   // Default sizes of the parameterized storage and datapath.
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DEF_PIXEL_BITS = 8;

   // Register file
   localparam int SIZE_W    = 11;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int MIN_SIZE  = 2;
   localparam logic [SIZE_W-1:0] DEF_FRAME_WIDTH  = 11'd640;
   localparam logic [SIZE_W-1:0] DEF_FRAME_HEIGHT = 11'd480;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_idx_type;

   // Item held behind the line memories and the results it still owes.
   typedef struct packed {
      logic valid;
      logic need_a;   // vertical result for the pixel above
      logic need_b;   // last-row result for the pixel to the left
      logic need_c;   // last-row result for this pixel, end of frame
   } gedge_ctl_type;

endpackage

`default_nettype wire

// ===== sv/wraparound_gradient_edge_top.sv =====
// Top level of the wraparound gradient edge detector.
// Depends on gedge_pkg, gedge_csr, gedge_front and gedge_emit.
`default_nettype none

// Takes grayscale pixels in raster order and returns, for each pixel, the
// contour value |below - p| + |right - p|, where the bottom row wraps to
// row 0 and the last column wraps to column 0 of the same row. Each result
// carries its row, column and an end-of-frame mark, and leaves in raster
// order once both neighbors are in. A pixel is accepted every cycle while
// results keep pace; the single output register issues one result per cycle
// while rsp_ready holds; on the bottom row, where each pixel after the first
// releases two results (three for the final pixel), a new pixel is taken
// only as the last result of the one before loads. Line memories are read as
// a pixel is accepted; its first result is offered once the output register
// is free to load it. The two line memories need no clearing after reset.
// Program frame_width (offset 0x0) and frame_height (offset 0x4) only while
// idle; sizes clamp to [2, MAX_WIDTH] and [2, MAX_HEIGHT].
module wraparound_gradient_edge_top
   import gedge_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [CSR_AW-1:0]               paddr,
   input  wire logic [CSR_DW-1:0]               pwdata,
   output logic      [CSR_DW-1:0]               prdata,
   output logic                                 pready,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [PIXEL_BITS-1:0]           req_pixel_value,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [PIXEL_BITS:0]             rsp_edge_value,
   output logic      [$clog2(MAX_HEIGHT)-1:0]   rsp_out_row,
   output logic      [$clog2(MAX_WIDTH)-1:0]    rsp_out_col,
   output logic                                 rsp_frame_last
);

   localparam int WD_W  = $clog2(MAX_WIDTH + 1);
   localparam int HD_W  = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic [WD_W-1:0]       width_eff;
   logic [HD_W-1:0]       height_eff;
   logic                  take;
   gedge_ctl_type         ctl;
   logic [PIXEL_BITS-1:0] op_px;
   logic [PIXEL_BITS-1:0] op_above;
   logic [PIXEL_BITS-1:0] op_above_right;
   logic [PIXEL_BITS-1:0] op_held;
   logic [PIXEL_BITS-1:0] op_top_left;
   logic [PIXEL_BITS-1:0] op_top_here;
   logic [PIXEL_BITS-1:0] op_row_first;
   logic [ROW_W-1:0]      op_row;
   logic [COL_W-1:0]      op_col;

   gedge_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .width_eff  (width_eff),
      .height_eff (height_eff)
   );

   gedge_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .width_eff       (width_eff),
      .height_eff      (height_eff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .take            (take),
      .ctl             (ctl),
      .op_px           (op_px),
      .op_above        (op_above),
      .op_above_right  (op_above_right),
      .op_held         (op_held),
      .op_top_left     (op_top_left),
      .op_top_here     (op_top_here),
      .op_row_first    (op_row_first),
      .op_row          (op_row),
      .op_col          (op_col)
   );

   gedge_emit #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_emit (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .op_px          (op_px),
      .op_above       (op_above),
      .op_above_right (op_above_right),
      .op_held        (op_held),
      .op_top_left    (op_top_left),
      .op_top_here    (op_top_here),
      .op_row_first   (op_row_first),
      .op_row         (op_row),
      .op_col         (op_col),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_value (rsp_edge_value),
      .rsp_out_row    (rsp_out_row),
      .rsp_out_col    (rsp_out_col),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

// ===== sv/gedge_csr.sv =====
// Configuration registers (APB-style) with size clamping.
// Depends on gedge_pkg.
`default_nettype none

module gedge_csr
   import gedge_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [CSR_AW-1:0]                paddr,
   input  wire logic [CSR_DW-1:0]                pwdata,
   output logic      [CSR_DW-1:0]                prdata,
   output logic                                  pready,
   output logic      [$clog2(MAX_WIDTH+1)-1:0]   width_eff,
   output logic      [$clog2(MAX_HEIGHT+1)-1:0]  height_eff
);

   localparam int WD_W = $clog2(MAX_WIDTH + 1);
   localparam int HD_W = $clog2(MAX_HEIGHT + 1);

   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] height_ff;
   reg_idx_type       reg_idx;
   logic              wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_idx_type'(paddr[2]);
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DEF_FRAME_WIDTH;
         height_ff <= DEF_FRAME_HEIGHT;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_FRAME_WIDTH:  width_ff  <= pwdata[SIZE_W-1:0];
            REG_FRAME_HEIGHT: height_ff <= pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FRAME_WIDTH:  prdata = CSR_DW'(width_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DW'(height_ff);
         default:          prdata = '0;
      endcase
   end

   // Clamp to [2, max]
   always_comb begin
      if (width_ff < SIZE_W'(MIN_SIZE)) begin
         width_eff = WD_W'(MIN_SIZE);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         width_eff = WD_W'(MAX_WIDTH);
      end else begin
         width_eff = WD_W'(width_ff);
      end
      if (height_ff < SIZE_W'(MIN_SIZE)) begin
         height_eff = HD_W'(MIN_SIZE);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         height_eff = HD_W'(MAX_HEIGHT);
      end else begin
         height_eff = HD_W'(height_ff);
      end
   end

endmodule

`default_nettype wire

// ===== sv/gedge_front.sv =====
// Raster position tracking, previous-row and top-row line memories, and the
// item register that lines up with the memory read data. Depends on gedge_pkg.
`default_nettype none

module gedge_front
   import gedge_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [$clog2(MAX_WIDTH+1)-1:0]     width_eff,
   input  wire logic [$clog2(MAX_HEIGHT+1)-1:0]    height_eff,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [PIXEL_BITS-1:0]              req_pixel_value,
   input  wire logic                               take,
   output gedge_ctl_type                           ctl,
   output logic      [PIXEL_BITS-1:0]              op_px,
   output logic      [PIXEL_BITS-1:0]              op_above,
   output logic      [PIXEL_BITS-1:0]              op_above_right,
   output logic      [PIXEL_BITS-1:0]              op_held,
   output logic      [PIXEL_BITS-1:0]              op_top_left,
   output logic      [PIXEL_BITS-1:0]              op_top_here,
   output logic      [PIXEL_BITS-1:0]              op_row_first,
   output logic      [$clog2(MAX_HEIGHT)-1:0]      op_row,
   output logic      [$clog2(MAX_WIDTH)-1:0]       op_col
);

   localparam int WD_W  = $clog2(MAX_WIDTH + 1);
   localparam int HD_W  = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   // Line memories
   logic [PIXEL_BITS-1:0] prev_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] top_mem  [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] prev_rd_ff;
   logic [PIXEL_BITS-1:0] top_rd_ff;

   // Position and row-edge pixels
   logic [ROW_W-1:0]      row_ff;
   logic [COL_W-1:0]      col_ff;
   logic [PIXEL_BITS-1:0] held_ff;
   logic [PIXEL_BITS-1:0] prev_first_ff;
   logic [PIXEL_BITS-1:0] cur_first_ff;

   // Item register behind the memories
   logic                  s1_valid_ff;
   logic                  s1_need_a_ff;
   logic                  s1_need_b_ff;
   logic                  s1_need_c_ff;
   logic                  s1_first_col_ff;
   logic                  s1_last_col_ff;
   logic [ROW_W-1:0]      s1_row_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic [PIXEL_BITS-1:0] s1_px_ff;
   logic [PIXEL_BITS-1:0] s1_held_ff;
   logic [PIXEL_BITS-1:0] s1_prev_first_ff;
   logic [PIXEL_BITS-1:0] s1_cur_first_ff;
   logic [PIXEL_BITS-1:0] above_hold_ff;
   logic [PIXEL_BITS-1:0] top_left_hold_ff;

   logic                  accept;
   logic                  restart;
   logic [ROW_W-1:0]      pos_row;
   logic [COL_W-1:0]      pos_col;
   logic                  first_col;
   logic                  first_row;
   logic                  last_col;
   logic                  last_row;
   logic [COL_W-1:0]      prev_rd_addr;
   logic [PIXEL_BITS-1:0] cur_first_in;

   assign req_ready = !s1_valid_ff || take;
   assign accept    = req_valid && req_ready;

   // A position outside a shrunken frame starts a new frame
   assign restart   = (WD_W'(col_ff) >= width_eff) || (HD_W'(row_ff) >= height_eff);
   assign pos_row   = restart ? '0 : row_ff;
   assign pos_col   = restart ? '0 : col_ff;
   assign first_col = (pos_col == '0);
   assign first_row = (pos_row == '0);
   assign last_col  = (WD_W'(pos_col) == width_eff - WD_W'(1));
   assign last_row  = (HD_W'(pos_row) == height_eff - HD_W'(1));

   assign prev_rd_addr = last_col ? '0 : pos_col + COL_W'(1);
   assign cur_first_in = first_col ? req_pixel_value : cur_first_ff;

   // Previous row: read one column ahead, write this column
   always_ff @(posedge clock) begin
      if (accept) begin
         prev_mem[pos_col] <= req_pixel_value;
         prev_rd_ff        <= prev_mem[prev_rd_addr];
      end
   end

   // Top row: written on row 0, read on the last row
   always_ff @(posedge clock) begin
      if (accept) begin
         if (first_row) begin
            top_mem[pos_col] <= req_pixel_value;
         end
         top_rd_ff <= top_mem[pos_col];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         held_ff       <= '0;
         prev_first_ff <= '0;
         cur_first_ff  <= '0;
         s1_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            held_ff      <= req_pixel_value;
            cur_first_ff <= cur_first_in;
            if (last_col) begin
               col_ff        <= '0;
               prev_first_ff <= cur_first_in;
               row_ff        <= last_row ? '0 : pos_row + ROW_W'(1);
            end else begin
               col_ff <= pos_col + COL_W'(1);
               row_ff <= pos_row;
            end
            s1_valid_ff <= 1'b1;
         end else if (take) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // Item payload; the previous item's read data become this item's above and top-left operands
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_need_a_ff     <= !first_row;
         s1_need_b_ff     <= last_row && !first_col;
         s1_need_c_ff     <= last_row && last_col;
         s1_first_col_ff  <= first_col;
         s1_last_col_ff   <= last_col;
         s1_row_ff        <= pos_row;
         s1_col_ff        <= pos_col;
         s1_px_ff         <= req_pixel_value;
         s1_held_ff       <= held_ff;
         s1_prev_first_ff <= prev_first_ff;
         s1_cur_first_ff  <= cur_first_in;
         above_hold_ff    <= prev_rd_ff;
         top_left_hold_ff <= top_rd_ff;
      end
   end

   assign ctl.valid  = s1_valid_ff;
   assign ctl.need_a = s1_need_a_ff;
   assign ctl.need_b = s1_need_b_ff;
   assign ctl.need_c = s1_need_c_ff;

   assign op_px          = s1_px_ff;
   assign op_above       = s1_first_col_ff ? s1_prev_first_ff : above_hold_ff;
   assign op_above_right = s1_last_col_ff ? s1_prev_first_ff : prev_rd_ff;
   assign op_held        = s1_held_ff;
   assign op_top_left    = top_left_hold_ff;
   assign op_top_here    = top_rd_ff;
   assign op_row_first   = s1_cur_first_ff;
   assign op_row         = s1_row_ff;
   assign op_col         = s1_col_ff;

   a_item_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item did not reach the item register");

   a_pos_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !take) |=> ($stable(row_ff) && $stable(col_ff)))
      else $error("position moved while the item register was busy");

endmodule

`default_nettype wire

// ===== sv/gedge_emit.sv =====
// Result sequencer: issues up to three results per item, computes the
// gradient sum and drives the output register. Depends on gedge_pkg.
`default_nettype none

module gedge_emit
   import gedge_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire gedge_ctl_type                   ctl,
   input  wire logic [PIXEL_BITS-1:0]           op_px,
   input  wire logic [PIXEL_BITS-1:0]           op_above,
   input  wire logic [PIXEL_BITS-1:0]           op_above_right,
   input  wire logic [PIXEL_BITS-1:0]           op_held,
   input  wire logic [PIXEL_BITS-1:0]           op_top_left,
   input  wire logic [PIXEL_BITS-1:0]           op_top_here,
   input  wire logic [PIXEL_BITS-1:0]           op_row_first,
   input  wire logic [$clog2(MAX_HEIGHT)-1:0]   op_row,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]    op_col,
   output logic                                 take,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [PIXEL_BITS:0]             rsp_edge_value,
   output logic      [$clog2(MAX_HEIGHT)-1:0]   rsp_out_row,
   output logic      [$clog2(MAX_WIDTH)-1:0]    rsp_out_col,
   output logic                                 rsp_frame_last
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int EDGE_W = PIXEL_BITS + 1;

   function automatic logic [PIXEL_BITS-1:0] abs_diff(
      input logic [PIXEL_BITS-1:0] a,
      input logic [PIXEL_BITS-1:0] b
   );
      return (a > b) ? a - b : b - a;
   endfunction

   logic [2:0]            done_ff;
   logic [2:0]            pend;
   logic [2:0]            sel;
   logic                  out_free;
   logic                  load;
   logic [PIXEL_BITS-1:0] p_op;
   logic [PIXEL_BITS-1:0] below_op;
   logic [PIXEL_BITS-1:0] right_op;
   logic [ROW_W-1:0]      res_row;
   logic [COL_W-1:0]      res_col;
   logic [EDGE_W-1:0]     edge_sum;

   logic                  rsp_valid_ff;
   logic [EDGE_W-1:0]     rsp_edge_ff;
   logic [ROW_W-1:0]      rsp_row_ff;
   logic [COL_W-1:0]      rsp_col_ff;
   logic                  rsp_last_ff;

   assign pend = ctl.valid ? ({ctl.need_c, ctl.need_b, ctl.need_a} & ~done_ff) : 3'b000;

   // Raster order: row above first, then left neighbor, then this pixel
   always_comb begin
      priority casez (pend)
         3'b??1:  sel = 3'b001;
         3'b?10:  sel = 3'b010;
         3'b100:  sel = 3'b100;
         default: sel = 3'b000;
      endcase
   end

   always_comb begin
      unique case (sel)
         3'b001: begin
            p_op     = op_above;
            below_op = op_px;
            right_op = op_above_right;
            res_row  = op_row - ROW_W'(1);
            res_col  = op_col;
         end
         3'b010: begin
            p_op     = op_held;
            below_op = op_top_left;
            right_op = op_px;
            res_row  = op_row;
            res_col  = op_col - COL_W'(1);
         end
         default: begin
            p_op     = op_px;
            below_op = op_top_here;
            right_op = op_row_first;
            res_row  = op_row;
            res_col  = op_col;
         end
      endcase
   end

   assign edge_sum = EDGE_W'(abs_diff(below_op, p_op)) + EDGE_W'(abs_diff(right_op, p_op));

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = (pend != 3'b000) && out_free;
   // Release the item once its final result goes out, or at once if it owes none
   assign take     = ctl.valid && ((pend == 3'b000) || (load && $onehot(pend)));

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= 3'b000;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            done_ff <= 3'b000;
         end else if (load) begin
            done_ff <= done_ff | sel;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_edge_ff <= edge_sum;
         rsp_row_ff  <= res_row;
         rsp_col_ff  <= res_col;
         rsp_last_ff <= sel[2];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = rsp_edge_ff;
   assign rsp_out_row    = rsp_row_ff;
   assign rsp_out_col    = rsp_col_ff;
   assign rsp_frame_last = rsp_last_ff;

   a_item_kept: assert property (@(posedge clock) disable iff (reset)
      (ctl.valid && !take) |=> ctl.valid)
      else $error("item released before all its results were issued");

   a_one_sel: assert property (@(posedge clock) disable iff (reset)
      $onehot0(sel))
      else $error("more than one result selected");

   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      load |-> ((sel & done_ff) == 3'b000))
      else $error("result issued twice for one item");

endmodule

`default_nettype wire

// ===== bench/wraparound_gradient_edge_top_tb.sv =====
`timescale 1ns / 100ps
// Bench for wraparound_gradient_edge_top: streams pixel frames at many sizes,
// predicts every contour result in raster order and checks each field.
// Depends on gedge_pkg and the wraparound_gradient_edge_top RTL.
module wraparound_gradient_edge_top_tb;
   import gedge_pkg::*;

   localparam int MAX_W           = DEF_MAX_WIDTH;
   localparam int MAX_H           = DEF_MAX_HEIGHT;
   localparam int PIX_W           = DEF_PIXEL_BITS;
   localparam int ROW_W           = $clog2(MAX_H);
   localparam int COL_W           = $clog2(MAX_W);
   localparam int CLK_HIGH        = 4;
   localparam int CLK_LOW         = 4;
   localparam int RESET_CYCLES    = 7;
   localparam int MAX_GAP         = 19;
   localparam int SETTLE_CYCLES   = 8;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int RANDOM_ITEMS    = 80;
   localparam int MAX_PRINTED     = 40;
   localparam logic [PIX_W-1:0] PIX_MAX = '1;

   typedef struct packed {
      logic [PIX_W:0]   contour_value;
      logic [ROW_W-1:0] row_idx;
      logic [COL_W-1:0] col_idx;
      logic             frame_end;
   } contour_result_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [CSR_AW-1:0]   paddr;
   logic [CSR_DW-1:0]   pwdata;
   logic [CSR_DW-1:0]   prdata;
   logic                pready;
   logic                req_valid;
   logic                req_ready;
   logic [PIX_W-1:0]    req_pixel_value;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [PIX_W:0]      rsp_edge_value;
   logic [ROW_W-1:0]    rsp_out_row;
   logic [COL_W-1:0]    rsp_out_col;
   logic                rsp_frame_last;

   bit                  req_idle_on  = 1'b1;
   bit                  rsp_idle_on  = 1'b1;
   bit                  rsp_hold_req = 1'b0;
   int unsigned         mismatch_count = 0;
   int unsigned         stall_cycles = 0;

   // Shadow of the block: sizes, line stores and raster position.
   logic [SIZE_W-1:0]   width_reg  = DEF_FRAME_WIDTH;
   logic [SIZE_W-1:0]   height_reg = DEF_FRAME_HEIGHT;
   logic [PIX_W-1:0]    prev_line [MAX_W];
   logic [PIX_W-1:0]    top_line [MAX_W];
   logic [PIX_W-1:0]    prev_first = '0;
   logic [PIX_W-1:0]    cur_first  = '0;
   logic [PIX_W-1:0]    held_px    = '0;
   int unsigned         row_pos = 0;
   int unsigned         col_pos = 0;
   int unsigned         narrowest_w = MAX_W;
   contour_result_type  pending_contours [$];

   wraparound_gradient_edge_top DUT (
      .clock           (clock),
      .reset           (reset),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_edge_value  (rsp_edge_value),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_frame_last  (rsp_frame_last)
   );

   always begin
      #CLK_LOW clock = 1'b1;
      #CLK_HIGH clock = 1'b0;
   end

   function automatic int unsigned clamp_dim(logic [SIZE_W-1:0] v, int unsigned top);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > top) return top;
      return 32'(v);
   endfunction

   function automatic logic [PIX_W:0] contour_of(logic [PIX_W-1:0] p,
                                                 logic [PIX_W-1:0] below,
                                                 logic [PIX_W-1:0] right);
      logic [PIX_W:0] dv;
      logic [PIX_W:0] dh;
      dv = {1'b0, (below > p) ? below - p : p - below};
      dh = {1'b0, (right > p) ? right - p : p - right};
      return dv + dh;
   endfunction

   // Pixels still needed to close the current frame; zero when the next pixel restarts.
   function automatic int unsigned frame_left();
      int unsigned w;
      int unsigned h;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      if (col_pos >= w || row_pos >= h) return 0;
      return (h - row_pos) * w - col_pos;
   endfunction

   // Widening past any width used in this frame would read line entries never written.
   function automatic bit size_change_safe(logic [SIZE_W-1:0] new_w, logic [SIZE_W-1:0] new_h);
      int unsigned w2;
      int unsigned h2;
      w2 = clamp_dim(new_w, MAX_W);
      h2 = clamp_dim(new_h, MAX_H);
      return (row_pos == 0) || (row_pos >= h2) || (col_pos >= w2) || (w2 <= narrowest_w);
   endfunction

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return PIX_MAX;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatch_count < MAX_PRINTED)
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, want, got);
      mismatch_count++;
   endtask

   task automatic compute_contours(input logic [PIX_W-1:0] px);
      int unsigned      w;
      int unsigned      h;
      int unsigned      r;
      int unsigned      c;
      logic [PIX_W-1:0] right;
      w = clamp_dim(width_reg, MAX_W);
      h = clamp_dim(height_reg, MAX_H);
      if (col_pos >= w || row_pos >= h) begin
         col_pos = 0;
         row_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      if (r == 0 && c == 0) narrowest_w = w;
      else if (w < narrowest_w) narrowest_w = w;
      if (c == 0) cur_first = px;
      // vertical neighbor arrived: release the pixel above
      if (r > 0) begin
         right = (c < w - 1) ? prev_line[COL_W'(c + 1)] : prev_first;
         pending_contours.push_back(contour_result_type'{
                                    contour_of(prev_line[COL_W'(c)], px, right),
                                    ROW_W'(r - 1), COL_W'(c), 1'b0});
      end
      // bottom row wraps down to row 0
      if (r == h - 1) begin
         if (c > 0)
            pending_contours.push_back(contour_result_type'{
                                       contour_of(held_px, top_line[COL_W'(c - 1)], px),
                                       ROW_W'(r), COL_W'(c - 1), 1'b0});
         if (c == w - 1)
            pending_contours.push_back(contour_result_type'{
                                       contour_of(px, top_line[COL_W'(c)], cur_first),
                                       ROW_W'(r), COL_W'(c), 1'b1});
      end
      if (r == 0) top_line[COL_W'(c)] = px;
      prev_line[COL_W'(c)] = px;
      held_px = px;
      c++;
      if (c >= w) begin
         c = 0;
         prev_first = cur_first;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   always @(posedge clock) begin : result_scoreboard
      contour_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_contours.size() == 0) begin
               report_mismatch("result with nothing outstanding", 32'd0,
                               32'(rsp_edge_value));
            end else begin
               want = pending_contours.pop_front();
               if (rsp_edge_value !== want.contour_value)
                  report_mismatch("edge_value", 32'(want.contour_value),
                                  32'(rsp_edge_value));
               if (rsp_out_row !== want.row_idx)
                  report_mismatch("out_row", 32'(want.row_idx), 32'(rsp_out_row));
               if (rsp_out_col !== want.col_idx)
                  report_mismatch("out_col", 32'(want.col_idx), 32'(rsp_out_col));
               if (rsp_frame_last !== want.frame_end)
                  report_mismatch("frame_last", 32'(want.frame_end), 32'(rsp_frame_last));
            end
         end
         if (req_valid && req_ready) compute_contours(req_pixel_value);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("wraparound_gradient_edge_top verification failed");
            $finish;
         end
      end
   end

   // Result sink: random gap per item, plus one long hold-off on request.
   initial begin : rsp_sink
      int unsigned gap;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = rsp_idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            gap += RSP_HOLD_CYCLES;
         end
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_pixel(input logic [PIX_W-1:0] px);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pixel_value <= px;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   // Drop valid, let the last item reach the predictor, drain every outstanding
   // result, then give the pipeline time to empty.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_contours.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_idx_type idx, input logic [SIZE_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'(4 * int'(idx));
      pwdata  <= CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_FRAME_WIDTH:  width_reg  = value;
         REG_FRAME_HEIGHT: height_reg = value;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check(input reg_idx_type idx, input logic [SIZE_W-1:0] want);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= CSR_AW'(4 * int'(idx));
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[SIZE_W-1:0] !== want)
         report_mismatch("register readback", 32'(want), 32'(prdata[SIZE_W-1:0]));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame_size(input logic [SIZE_W-1:0] w, input logic [SIZE_W-1:0] h);
      settle();
      if (!size_change_safe(w, h)) w = SIZE_W'(narrowest_w);
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      csr_read_check(REG_FRAME_WIDTH, w);
      csr_read_check(REG_FRAME_HEIGHT, h);
   endtask

   task automatic complete_frame();
      int unsigned n;
      n = (row_pos != 0 || col_pos != 0) ? frame_left() : 0;
      repeat (n) send_pixel(random_pixel());
   endtask

   task automatic test_reset_defaults();
      csr_read_check(REG_FRAME_WIDTH, DEF_FRAME_WIDTH);
      csr_read_check(REG_FRAME_HEIGHT, DEF_FRAME_HEIGHT);
      // row 0 of a 640-wide frame: no result may appear
      repeat (6) send_pixel(random_pixel());
      settle();
   endtask

   task automatic test_directed();
      set_frame_size(SIZE_W'(2), SIZE_W'(2));
      send_pixel('0);
      send_pixel(PIX_MAX);
      send_pixel(PIX_MAX);
      send_pixel('0);
      // sizes below the minimum act as 2x2
      set_frame_size(SIZE_W'(0), SIZE_W'(1));
      send_pixel(PIX_MAX);
      send_pixel('0);
      send_pixel('0);
      send_pixel(PIX_MAX);
      set_frame_size(SIZE_W'(3), SIZE_W'(3));
      for (int i = 0; i < 9; i++) send_pixel((i % 2) ? PIX_MAX : '0);
      // shrink height mid-frame so the current row becomes the bottom row
      repeat (4) send_pixel(random_pixel());
      set_frame_size(SIZE_W'(3), SIZE_W'(2));
      complete_frame();
      settle();
   endtask

   task automatic test_random_frames();
      int unsigned       sent;
      int unsigned       n;
      logic [SIZE_W-1:0] w;
      logic [SIZE_W-1:0] h;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         w = SIZE_W'($urandom_range(2, 10));
         h = SIZE_W'($urandom_range(2, 6));
         if ($urandom_range(0, 7) == 0) w = SIZE_W'($urandom_range(0, 1));
         if ($urandom_range(0, 7) == 0) h = SIZE_W'($urandom_range(0, 1));
         set_frame_size(w, h);
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         n = frame_left();
         if (n == 0) n = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
         // cut some frames short so the next size lands mid-frame
         if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
         repeat (n) send_pixel(random_pixel());
         sent += n;
      end
      complete_frame();
      settle();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   task automatic test_output_stall();
      set_frame_size(SIZE_W'(6), SIZE_W'(4));
      req_idle_on  = 1'b0;
      rsp_hold_req = 1'b1;
      repeat (72) send_pixel(random_pixel());
      settle();
      req_idle_on = 1'b1;
   endtask

   task automatic test_size_extremes();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      set_frame_size(SIZE_W'(MAX_W), SIZE_W'(2));
      repeat (40) send_pixel(random_pixel());
      // all-ones register values clamp to the maximum frame
      set_frame_size('1, '1);
      repeat (40) send_pixel(random_pixel());
      set_frame_size(SIZE_W'(2), SIZE_W'(MAX_H));
      repeat (40) send_pixel(random_pixel());
      settle();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin : run_tests
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_pixel_value <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed();
      test_random_frames();
      test_output_stall();
      test_size_extremes();
      if (mismatch_count == 0) begin
         $display("wraparound_gradient_edge_top verification clean");
      end else begin
         $display("wraparound_gradient_edge_top verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/gedge_pkg.sv
sv/gedge_csr.sv
sv/gedge_front.sv
sv/gedge_emit.sv
sv/wraparound_gradient_edge_top.sv
bench/wraparound_gradient_edge_top_tb.sv
